// ===== hw/rtl/ptwsr_pkg.sv =====
package ptwsr_pkg;

   // Default sizes of the table.
   localparam int SLOTS_DEF      = 8;
   localparam int ADDR_BITS_DEF  = 48;
   localparam int SCORE_BITS_DEF = 32;
   localparam int TICK_BITS_DEF  = 32;

   // Request codes.
   localparam logic [2:0] FUNC_INSERT = 3'd0;
   localparam logic [2:0] FUNC_REMOVE = 3'd1;
   localparam logic [2:0] FUNC_RAISE  = 3'd2;
   localparam logic [2:0] FUNC_LOWER  = 3'd3;
   localparam logic [2:0] FUNC_QUERY  = 3'd4;
   localparam logic [2:0] FUNC_TICK   = 3'd5;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_PRESENT   = 2'd1;
   localparam logic [1:0] STATUS_DEFERRED  = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // Register file layout.
   localparam int         CSR_ADDR_W      = 3;
   localparam int         CSR_DATA_W      = 32;
   localparam int         MAX_PEERS_W     = 4;
   localparam int         STASIS_W        = 32;
   localparam logic       REG_MAX_PEERS   = 1'b0;
   localparam logic       REG_STASIS      = 1'b1;
   localparam logic [MAX_PEERS_W-1:0] MAX_PEERS_RESET = 4'd8;
   localparam logic [STASIS_W-1:0]    STASIS_RESET    = 32'd60;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   // Control of the slot search unit.
   typedef struct packed {
      logic clear;
      logic load;
   } scan_ctl_type;

   // Outcome flags of the slot search.
   typedef struct packed {
      logic hit;
      logic worst_found;
      logic free_found;
   } search_flags_type;

endpackage

// ===== hw/rtl/ptwsr_csr.sv =====
module ptwsr_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ptwsr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ptwsr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ptwsr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready,
   output logic [ptwsr_pkg::MAX_PEERS_W-1:0]     max_peers,
   output logic [ptwsr_pkg::STASIS_W-1:0]        stasis_ticks
);

   logic [ptwsr_pkg::MAX_PEERS_W-1:0] max_peers_ff;
   logic [ptwsr_pkg::STASIS_W-1:0]    stasis_ff;
   logic                              wr_en;
   logic                              reg_sel;

   // Registers sit on word addresses, so bit 2 selects between them.
   assign reg_sel    = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_peers_ff <= ptwsr_pkg::MAX_PEERS_RESET;
         stasis_ff    <= ptwsr_pkg::STASIS_RESET;
      end else if (wr_en) begin
         if (reg_sel == ptwsr_pkg::REG_MAX_PEERS) begin
            max_peers_ff <= csr_pwdata[ptwsr_pkg::MAX_PEERS_W-1:0];
         end else begin
            stasis_ff <= csr_pwdata[ptwsr_pkg::STASIS_W-1:0];
         end
      end
   end

   // Read-back of the selected register.
   always_comb begin
      if (reg_sel == ptwsr_pkg::REG_STASIS) begin
         csr_prdata = stasis_ff;
      end else begin
         csr_prdata = ptwsr_pkg::CSR_DATA_W'(max_peers_ff);
      end
   end

   assign max_peers    = max_peers_ff;
   assign stasis_ticks = stasis_ff;

endmodule

// ===== hw/rtl/ptwsr_search.sv =====
module ptwsr_search #(
   parameter int SLOTS      = ptwsr_pkg::SLOTS_DEF,
   parameter int ADDR_BITS  = ptwsr_pkg::ADDR_BITS_DEF,
   parameter int SCORE_BITS = ptwsr_pkg::SCORE_BITS_DEF,
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ptwsr_pkg::scan_ctl_type         ctl,
   input  logic [IDX_W-1:0]                slot_idx,
   input  logic                            slot_valid,
   input  logic [ADDR_BITS-1:0]            slot_key,
   input  logic signed [SCORE_BITS-1:0]    slot_score,
   input  logic [ADDR_BITS-1:0]            match_key,
   output ptwsr_pkg::search_flags_type     flags,
   output logic [IDX_W-1:0]                at_idx,
   output logic signed [SCORE_BITS-1:0]    at_score,
   output logic [IDX_W-1:0]                worst_idx,
   output logic [ADDR_BITS-1:0]            worst_key,
   output logic [IDX_W-1:0]                free_idx
);

   ptwsr_pkg::search_flags_type         flags_ff;
   ptwsr_pkg::search_flags_type         flags_in;
   logic [IDX_W-1:0]                    at_idx_ff;
   logic signed [SCORE_BITS-1:0]        at_score_ff;
   logic [IDX_W-1:0]                    worst_idx_ff;
   logic signed [SCORE_BITS-1:0]        worst_score_ff;
   logic [ADDR_BITS-1:0]                worst_key_ff;
   logic [IDX_W-1:0]                    free_idx_ff;
   logic                                take_hit;
   logic                                take_worst;
   logic                                take_free;

   // One slot arrives per cycle. The worst slot is replaced only on a strictly
   // lower score, so ties stay with the lowest slot; the first free slot wins.
   assign take_hit   = ctl.load & slot_valid & (slot_key == match_key);
   assign take_worst = ctl.load & slot_valid &
                       (~flags_ff.worst_found | (slot_score < worst_score_ff));
   assign take_free  = ctl.load & ~slot_valid & ~flags_ff.free_found;

   always_comb begin
      flags_in = flags_ff;
      if (ctl.clear) begin
         flags_in = '0;
      end else begin
         if (take_hit) begin
            flags_in.hit = 1'b1;
         end
         if (take_worst) begin
            flags_in.worst_found = 1'b1;
         end
         if (take_free) begin
            flags_in.free_found = 1'b1;
         end
      end
   end

   // Outcome flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // Captured slot data for the outcome.
   always_ff @(posedge clock) begin
      if (take_hit) begin
         at_idx_ff   <= slot_idx;
         at_score_ff <= slot_score;
      end
      if (take_worst) begin
         worst_idx_ff   <= slot_idx;
         worst_score_ff <= slot_score;
         worst_key_ff   <= slot_key;
      end
      if (take_free) begin
         free_idx_ff <= slot_idx;
      end
   end

   assign flags     = flags_ff;
   assign at_idx    = at_idx_ff;
   assign at_score  = at_score_ff;
   assign worst_idx = worst_idx_ff;
   assign worst_key = worst_key_ff;
   assign free_idx  = free_idx_ff;

endmodule

// ===== hw/rtl/peer_table_worst_score_replace.sv =====
// The scan reads the key and score memories one slot per cycle; the apply step then updates
// the table and registers the result, waiting while an earlier result is not yet taken.
// Requests are taken one at a time: a new one is accepted only once the block is idle again.
// Reset: synchronous; the table is empty, all scores read as zero, the tick count is zero,
// max_peers is 8 and stasis_ticks is 60. No clearing pass is needed after reset.
module peer_table_worst_score_replace #(
   parameter int SLOTS      = ptwsr_pkg::SLOTS_DEF,
   parameter int ADDR_BITS  = ptwsr_pkg::ADDR_BITS_DEF,
   parameter int SCORE_BITS = ptwsr_pkg::SCORE_BITS_DEF,
   parameter int TICK_BITS  = ptwsr_pkg::TICK_BITS_DEF,
   localparam int CNT_W     = $clog2(SLOTS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_func,
   input  logic [ADDR_BITS-1:0]                req_peer_addr,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_found,
   output logic                                rsp_evicted_valid,
   output logic [ADDR_BITS-1:0]                rsp_evicted_addr,
   output logic [CNT_W-1:0]                    rsp_peer_count,
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ptwsr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptwsr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ptwsr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W = 8;
   localparam int ST_W  = (TICK_BITS > ptwsr_pkg::STASIS_W) ? TICK_BITS : ptwsr_pkg::STASIS_W;
   localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
   localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

   // Configuration.
   logic [ptwsr_pkg::MAX_PEERS_W-1:0]  max_peers;
   logic [ptwsr_pkg::STASIS_W-1:0]     stasis_ticks;

   // Controller.
   ptwsr_pkg::state_type               state_ff;
   ptwsr_pkg::state_type               state_in;
   logic [CNT_W-1:0]                   scan_cnt_ff;
   logic [CNT_W-1:0]                   scan_cnt_in;
   logic                               rd_pend_ff;
   logic [IDX_W-1:0]                   rd_idx_ff;
   logic                               rd_en;
   logic                               accept;
   logic                               apply_go;

   // Captured request.
   logic [2:0]                         func_ff;
   logic [ADDR_BITS-1:0]               addr_ff;

   // Table state held in flip-flops.
   logic [SLOTS-1:0]                   valid_ff;
   logic [SLOTS-1:0]                   valid_in;
   logic [SLOTS-1:0]                   zero_ff;
   logic [SLOTS-1:0]                   zero_in;
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic [TICK_BITS-1:0]               ticks_ff;
   logic [TICK_BITS-1:0]               ticks_in;

   // Key and score memories.
   logic [ADDR_BITS-1:0]               key_mem_ff   [SLOTS];
   logic signed [SCORE_BITS-1:0]       score_mem_ff [SLOTS];
   logic [ADDR_BITS-1:0]               key_q_ff;
   logic signed [SCORE_BITS-1:0]       score_q_ff;
   logic                               key_we;
   logic                               score_we;
   logic [IDX_W-1:0]                   wr_idx;
   logic signed [SCORE_BITS-1:0]       score_wdata;

   // Search unit.
   ptwsr_pkg::scan_ctl_type            scan_ctl;
   ptwsr_pkg::search_flags_type        flags;
   logic [IDX_W-1:0]                   at_idx;
   logic signed [SCORE_BITS-1:0]       at_score;
   logic [IDX_W-1:0]                   worst_idx;
   logic [ADDR_BITS-1:0]               worst_key;
   logic [IDX_W-1:0]                   free_idx;
   logic signed [SCORE_BITS-1:0]       slot_score;

   // Decision terms.
   logic [CMP_W-1:0]                   limit;
   logic                               full;
   logic                               in_stasis;
   logic [CNT_W-1:0]                   ins_count;

   // Result register.
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [1:0]                         status_ff;
   logic [1:0]                         status_in;
   logic                               found_ff;
   logic                               found_in;
   logic                               ev_valid_ff;
   logic                               ev_valid_in;
   logic [ADDR_BITS-1:0]               ev_addr_ff;
   logic [ADDR_BITS-1:0]               ev_addr_in;

   ptwsr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .max_peers    (max_peers),
      .stasis_ticks (stasis_ticks)
   );

   // A slot whose zero mark is set reads as score zero, whatever the memory holds.
   assign slot_score = zero_ff[rd_idx_ff] ? '0 : score_q_ff;

   assign scan_ctl.clear = accept;
   assign scan_ctl.load  = rd_pend_ff;

   ptwsr_search #(
      .SLOTS      (SLOTS),
      .ADDR_BITS  (ADDR_BITS),
      .SCORE_BITS (SCORE_BITS)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .slot_idx   (rd_idx_ff),
      .slot_valid (valid_ff[rd_idx_ff]),
      .slot_key   (key_q_ff),
      .slot_score (slot_score),
      .match_key  (addr_ff),
      .flags      (flags),
      .at_idx     (at_idx),
      .at_score   (at_score),
      .worst_idx  (worst_idx),
      .worst_key  (worst_key),
      .free_idx   (free_idx)
   );

   // Reads happen only in the scan and writes only in the apply cycle, so the
   // two never touch the same entry at once and no forwarding is needed.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_q_ff   <= key_mem_ff[scan_cnt_ff[IDX_W-1:0]];
         score_q_ff <= score_mem_ff[scan_cnt_ff[IDX_W-1:0]];
      end
      if (key_we) begin
         key_mem_ff[wr_idx] <= addr_ff;
      end
      if (score_we) begin
         score_mem_ff[wr_idx] <= score_wdata;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         addr_ff <= req_peer_addr;
      end
   end

   // Effective limit is max_peers clamped to one through the slot count.
   always_comb begin
      if (max_peers == '0) begin
         limit = CMP_W'(1);
      end else if (CMP_W'(max_peers) > CMP_W'(SLOTS)) begin
         limit = CMP_W'(SLOTS);
      end else begin
         limit = CMP_W'(max_peers);
      end
   end

   assign full      = CMP_W'(count_ff) >= limit;
   assign in_stasis = ST_W'(ticks_ff) < ST_W'(stasis_ticks);
   assign ins_count = full ? count_ff : count_ff + CNT_W'(1);

   assign req_ready = (state_ff == ptwsr_pkg::ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign apply_go  = (state_ff == ptwsr_pkg::ST_APPLY) & (~rsp_valid_ff | rsp_ready);

   // Next state, scan sequencing and the update of one item.
   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      rd_en        = 1'b0;
      valid_in     = valid_ff;
      zero_in      = zero_ff;
      count_in     = count_ff;
      ticks_in     = ticks_ff;
      key_we       = 1'b0;
      score_we     = 1'b0;
      wr_idx       = at_idx;
      score_wdata  = at_score;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      status_in    = status_ff;
      found_in     = found_ff;
      ev_valid_in  = ev_valid_ff;
      ev_addr_in   = ev_addr_ff;

      case (state_ff)
         ptwsr_pkg::ST_IDLE: begin
            scan_cnt_in = '0;
            if (accept) begin
               state_in = ptwsr_pkg::ST_SCAN;
            end
         end
         ptwsr_pkg::ST_SCAN: begin
            if (scan_cnt_ff != CNT_W'(SLOTS)) begin
               rd_en       = 1'b1;
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end else begin
               // The last slot is being taken in by the search unit this cycle.
               state_in = ptwsr_pkg::ST_APPLY;
            end
         end
         ptwsr_pkg::ST_APPLY: begin
            if (apply_go) begin
               state_in     = ptwsr_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = ptwsr_pkg::STATUS_DONE;
               found_in     = flags.hit & (func_ff <= ptwsr_pkg::FUNC_QUERY);
               ev_valid_in  = 1'b0;
               ev_addr_in   = '0;
               case (func_ff)
                  ptwsr_pkg::FUNC_INSERT: begin
                     if (full & in_stasis) begin
                        status_in = ptwsr_pkg::STATUS_DEFERRED;
                     end else if (flags.hit) begin
                        status_in = ptwsr_pkg::STATUS_PRESENT;
                     end else begin
                        ticks_in = '0;
                        if (full & flags.worst_found) begin
                           ev_valid_in = 1'b1;
                           ev_addr_in  = worst_key;
                           wr_idx      = worst_idx;
                        end else begin
                           wr_idx = free_idx;
                        end
                        if ((full & flags.worst_found) | (~full & flags.free_found)) begin
                           key_we           = 1'b1;
                           valid_in[wr_idx] = 1'b1;
                           zero_in[wr_idx]  = 1'b1;
                           count_in         = ins_count;
                        end
                        // Filling the table restarts every score from zero.
                        if (CMP_W'(count_in) >= limit) begin
                           zero_in = '1;
                        end
                     end
                  end
                  ptwsr_pkg::FUNC_REMOVE: begin
                     if (flags.hit) begin
                        valid_in[at_idx] = 1'b0;
                        zero_in[at_idx]  = 1'b1;
                        count_in         = count_ff - CNT_W'(1);
                     end else begin
                        status_in = ptwsr_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  ptwsr_pkg::FUNC_RAISE,
                  ptwsr_pkg::FUNC_LOWER: begin
                     if (!flags.hit) begin
                        status_in = ptwsr_pkg::STATUS_NOT_FOUND;
                     end else if (full) begin
                        // Saturating step of the score.
                        if (func_ff == ptwsr_pkg::FUNC_RAISE) begin
                           if (at_score != SCORE_MAX) begin
                              score_wdata = at_score + SCORE_BITS'(1);
                           end
                        end else begin
                           if (at_score != SCORE_MIN) begin
                              score_wdata = at_score - SCORE_BITS'(1);
                           end
                        end
                        score_we        = 1'b1;
                        zero_in[at_idx] = 1'b0;
                     end
                  end
                  ptwsr_pkg::FUNC_QUERY: begin
                     if (!flags.hit) begin
                        status_in = ptwsr_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  ptwsr_pkg::FUNC_TICK: begin
                     if (ticks_ff != '1) begin
                        ticks_in = ticks_ff + TICK_BITS'(1);
                     end
                  end
                  default: begin
                     // Unused codes leave the table alone.
                  end
               endcase
            end
         end
         default: begin
            state_in = ptwsr_pkg::ST_IDLE;
         end
      endcase
   end

   // Controller and table registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptwsr_pkg::ST_IDLE;
         scan_cnt_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         zero_ff      <= '1;
         count_ff     <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rd_pend_ff   <= rd_en;
         valid_ff     <= valid_in;
         zero_ff      <= zero_in;
         count_ff     <= count_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Slot index of the data coming back from the memories.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_idx_ff <= scan_cnt_ff[IDX_W-1:0];
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (apply_go) begin
         status_ff   <= status_in;
         found_ff    <= found_in;
         ev_valid_ff <= ev_valid_in;
         ev_addr_ff  <= ev_addr_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_found         = found_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_addr  = ev_addr_ff;
   assign rsp_peer_count    = count_ff;

`ifndef ASSERT_OFF
   // The peer count always agrees with the valid bits.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == count_ff)
      else $error("peer count differs from valid slots");

   // A result appears only after an apply cycle.
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ptwsr_pkg::ST_APPLY))
      else $error("result raised outside apply");

   // An eviction is reported only by a completed insert.
   a_evict_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ev_valid_ff) |-> (status_ff == ptwsr_pkg::STATUS_DONE))
      else $error("eviction with non-done status");

   // Memory writes never overlap the scan.
   a_write_in_apply: assert property (@(posedge clock) disable iff (reset)
      (key_we || score_we) |-> (state_ff == ptwsr_pkg::ST_APPLY) && !rd_en)
      else $error("memory write outside apply");
`endif

endmodule

// ===== bench/peer_table_worst_score_replace_check.sv =====
`timescale 1ns / 1ps
module peer_table_worst_score_replace_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [2:0]                          req_func,
   input  logic [ptwsr_pkg::ADDR_BITS_DEF-1:0] req_peer_addr,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [1:0]                          rsp_status,
   input  logic                                rsp_found,
   input  logic                                rsp_evicted_valid,
   input  logic [ptwsr_pkg::ADDR_BITS_DEF-1:0] rsp_evicted_addr,
   input  logic [3:0]                          rsp_peer_count,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ptwsr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptwsr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  logic [ptwsr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   input  logic                                csr_pready,
   output int                                  mismatches,
   output int                                  outstanding,
   output int                                  evictions,
   output int                                  deferrals
);

   localparam int SLOTS   = ptwsr_pkg::SLOTS_DEF;
   localparam int ADDR_W  = ptwsr_pkg::ADDR_BITS_DEF;
   localparam int SCORE_W = ptwsr_pkg::SCORE_BITS_DEF;
   localparam int TICK_W  = ptwsr_pkg::TICK_BITS_DEF;
   localparam int CA_W    = ptwsr_pkg::CSR_ADDR_W;
   localparam int CD_W    = ptwsr_pkg::CSR_DATA_W;

   localparam logic signed [SCORE_W-1:0] SCORE_TOP    = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_BOTTOM = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic [CA_W-1:0] ADDR_LIMIT  = {ptwsr_pkg::REG_MAX_PEERS, 2'b00};
   localparam logic [CA_W-1:0] ADDR_STASIS = {ptwsr_pkg::REG_STASIS, 2'b00};

   // One result item as the block should present it.
   typedef struct packed {
      logic [1:0]        status;
      logic              found;
      logic              evicted_valid;
      logic [ADDR_W-1:0] evicted_addr;
      logic [3:0]        peer_count;
   } peer_outcome_type;

   // Shadow copy of the peer table and its registers.
   logic [ADDR_W-1:0]                   slot_addr [SLOTS];
   bit                                  slot_used [SLOTS];
   logic signed [SCORE_W-1:0]           peer_score [SLOTS];
   logic [TICK_W-1:0]                   ticks_since_add;
   logic [ptwsr_pkg::MAX_PEERS_W-1:0]   cfg_limit;
   logic [ptwsr_pkg::STASIS_W-1:0]      cfg_stasis;

   peer_outcome_type awaited_outcomes [$];

   function automatic int occupancy();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i]) n++;
      return n;
   endfunction

   // Applies one request to the shadow table and returns the result it should give.
   function automatic peer_outcome_type apply_request(input logic [2:0] f,
                                                      input logic [ADDR_W-1:0] a);
      peer_outcome_type o;
      int at, worst, slot, lim, i;
      bit full;
      o = '0;
      at = -1;
      for (i = 0; i < SLOTS; i++)
         if (at < 0 && slot_used[i] && slot_addr[i] == a) at = i;
      lim = (cfg_limit < 1) ? 1 : ((cfg_limit > SLOTS) ? SLOTS : int'(cfg_limit));
      full = occupancy() >= lim;
      if (f <= ptwsr_pkg::FUNC_QUERY && at >= 0) o.found = 1'b1;
      o.status = ptwsr_pkg::STATUS_DONE;
      case (f)
         ptwsr_pkg::FUNC_INSERT: begin
            // Stasis is checked before the duplicate test.
            if (full && ticks_since_add < cfg_stasis) begin
               o.status = ptwsr_pkg::STATUS_DEFERRED;
            end else if (at >= 0) begin
               o.status = ptwsr_pkg::STATUS_PRESENT;
            end else begin
               slot = -1;
               if (full) begin
                  // Lowest score goes, ties to the lowest slot.
                  worst = -1;
                  for (i = 0; i < SLOTS; i++)
                     if (slot_used[i] && (worst < 0 || peer_score[i] < peer_score[worst]))
                        worst = i;
                  o.evicted_valid = 1'b1;
                  o.evicted_addr  = slot_addr[worst];
                  slot = worst;
               end else begin
                  for (i = SLOTS - 1; i >= 0; i--)
                     if (!slot_used[i]) slot = i;
               end
               slot_used[slot]  = 1'b1;
               slot_addr[slot]  = a;
               peer_score[slot] = '0;
               ticks_since_add  = '0;
               // Filling the table wipes every score.
               if (occupancy() >= lim)
                  for (i = 0; i < SLOTS; i++) peer_score[i] = '0;
            end
         end
         ptwsr_pkg::FUNC_REMOVE: begin
            if (at >= 0) begin
               slot_used[at]  = 1'b0;
               peer_score[at] = '0;
            end else begin
               o.status = ptwsr_pkg::STATUS_NOT_FOUND;
            end
         end
         ptwsr_pkg::FUNC_RAISE, ptwsr_pkg::FUNC_LOWER: begin
            if (at < 0) begin
               o.status = ptwsr_pkg::STATUS_NOT_FOUND;
            end else if (full) begin
               if (f == ptwsr_pkg::FUNC_RAISE && peer_score[at] != SCORE_TOP)
                  peer_score[at] = peer_score[at] + 1;
               else if (f == ptwsr_pkg::FUNC_LOWER && peer_score[at] != SCORE_BOTTOM)
                  peer_score[at] = peer_score[at] - 1;
            end
         end
         ptwsr_pkg::FUNC_QUERY: begin
            if (at < 0) o.status = ptwsr_pkg::STATUS_NOT_FOUND;
         end
         ptwsr_pkg::FUNC_TICK: begin
            if (ticks_since_add != '1) ticks_since_add = ticks_since_add + 1'b1;
         end
         default: begin
         end
      endcase
      o.peer_count = 4'(occupancy());
      return o;
   endfunction

   task automatic log_failure(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: %s", $realtime, msg);
   endtask

   // Watch both channels and the register port at every rising edge.
   always @(posedge clock) begin : watch
      peer_outcome_type want, got;
      logic [CD_W-1:0] reg_now;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_addr[i]  = '0;
            peer_score[i] = '0;
         end
         ticks_since_add = '0;
         cfg_limit  = ptwsr_pkg::MAX_PEERS_RESET;
         cfg_stasis = ptwsr_pkg::STASIS_RESET;
         awaited_outcomes.delete();
         mismatches = 0;
         evictions  = 0;
         deferrals  = 0;
      end else begin
         // Results are checked before the item accepted at the same edge is predicted.
         if (rsp_valid && rsp_ready) begin
            got.status        = rsp_status;
            got.found         = rsp_found;
            got.evicted_valid = rsp_evicted_valid;
            got.evicted_addr  = rsp_evicted_addr;
            got.peer_count    = rsp_peer_count;
            if (awaited_outcomes.size() == 0) begin
               log_failure("result item arrived with no request outstanding");
            end else begin
               want = awaited_outcomes.pop_front();
               if (got !== want)
                  log_failure($sformatf({"result mismatch: expected status %0d found %0d ",
                     "evicted %0d/%h count %0d, got status %0d found %0d evicted %0d/%h ",
                     "count %0d"}, want.status, want.found, want.evicted_valid,
                     want.evicted_addr, want.peer_count, got.status, got.found,
                     got.evicted_valid, got.evicted_addr, got.peer_count));
            end
         end
         if (req_valid && req_ready) begin
            want = apply_request(req_func, req_peer_addr);
            if (want.evicted_valid) evictions++;
            if (want.status == ptwsr_pkg::STATUS_DEFERRED) deferrals++;
            awaited_outcomes.push_back(want);
         end
         // Register reads must return what was last written.
         if (csr_psel && csr_penable && !csr_pwrite && csr_pready) begin
            reg_now = (csr_paddr == ADDR_LIMIT) ? CD_W'(cfg_limit) : cfg_stasis;
            if (csr_prdata !== reg_now)
               log_failure($sformatf("register read at %0d: expected %h, got %h",
                  csr_paddr, reg_now, csr_prdata));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_LIMIT)
               cfg_limit = csr_pwdata[ptwsr_pkg::MAX_PEERS_W-1:0];
            else if (csr_paddr == ADDR_STASIS)
               cfg_stasis = csr_pwdata[ptwsr_pkg::STASIS_W-1:0];
         end
      end
      outstanding <= awaited_outcomes.size();
   end

endmodule

// ===== bench/peer_table_worst_score_replace_tb.sv =====
`timescale 1ns / 1ps
module peer_table_worst_score_replace_tb;

   localparam int ADDR_W      = ptwsr_pkg::ADDR_BITS_DEF;
   localparam int CNT_W       = $clog2(ptwsr_pkg::SLOTS_DEF + 1);
   localparam int CA_W        = ptwsr_pkg::CSR_ADDR_W;
   localparam int CD_W        = ptwsr_pkg::CSR_DATA_W;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 95;
   localparam int POOL        = 10;
   localparam int HOLD_CYCLES = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_func = ptwsr_pkg::FUNC_QUERY;
   logic [ADDR_W-1:0]     req_peer_addr = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_status;
   logic                  rsp_found;
   logic                  rsp_evicted_valid;
   logic [ADDR_W-1:0]     rsp_evicted_addr;
   logic [CNT_W-1:0]      rsp_peer_count;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CA_W-1:0]       csr_paddr = '0;
   logic [CD_W-1:0]       csr_pwdata = '0;
   logic [CD_W-1:0]       csr_prdata;
   logic                  csr_pready;

   int mismatches, outstanding, evictions, deferrals;
   int items_sent = 0;
   int settings_used = 0;
   bit idle_on = 1'b0;
   bit hold_rsp = 1'b0;
   bit pressure_go = 1'b0;
   logic [ADDR_W-1:0] addr_pool [POOL];

   always #2 clock = ~clock;

   peer_table_worst_score_replace dut (.*);

   peer_table_worst_score_replace_check checker_i (.*);

   // Result side: random hold-off per item, plus one long stall on request.
   initial begin : result_sink
      int gap;
      forever begin
         gap = idle_on ? $urandom_range(0, 5) : 0;
         repeat (gap) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
         while (hold_rsp) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // The long stall is timed here, independently of the request stream.
   initial begin : long_stall
      do @(posedge clock); while (!pressure_go);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : watchdog
      #2_000_000;
      $display("peer_table_worst_score_replace regression: fail");
      $finish;
   end

   // Offers one item and returns at the edge where it is taken.
   task automatic offer_request(input logic [2:0] f, input logic [ADDR_W-1:0] a);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_peer_addr <= a;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Returns once every result item has come back.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic sel, input logic [CD_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes both registers in random order and reads them back; block must be idle.
   task automatic apply_settings(input logic [3:0] lim, input logic [31:0] stasis);
      if ($urandom_range(0, 1)) begin
         csr_access(1'b1, ptwsr_pkg::REG_MAX_PEERS, {28'd0, lim});
         csr_access(1'b1, ptwsr_pkg::REG_STASIS, stasis);
      end else begin
         csr_access(1'b1, ptwsr_pkg::REG_STASIS, stasis);
         csr_access(1'b1, ptwsr_pkg::REG_MAX_PEERS, {28'd0, lim});
      end
      csr_access(1'b0, ptwsr_pkg::REG_MAX_PEERS, '0);
      csr_access(1'b0, ptwsr_pkg::REG_STASIS, '0);
      settings_used++;
   endtask

   function automatic logic [ADDR_W-1:0] fresh_addr();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[ADDR_W-1:0];
   endfunction

   // Random traffic over a small address pool so that entries hit, fill and evict.
   task automatic run_traffic_phase(input logic [3:0] lim, input logic [31:0] stasis,
                                    input bit stall);
      logic [2:0] f;
      logic [ADDR_W-1:0] a;
      int pick, bitpos, counted;
      wait_for_idle();
      apply_settings(lim, stasis);
      idle_on <= ($urandom_range(0, 3) != 0);
      if (stall) pressure_go <= 1'b1;
      // Keep at least half the pool so earlier entries stay reachable.
      for (int k = 0; k < POOL / 2; k++) addr_pool[$urandom_range(0, POOL - 1)] = fresh_addr();
      counted = 0;
      while (counted < PHASE_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 25)      f = ptwsr_pkg::FUNC_INSERT;
         else if (pick < 35) f = ptwsr_pkg::FUNC_REMOVE;
         else if (pick < 50) f = ptwsr_pkg::FUNC_RAISE;
         else if (pick < 65) f = ptwsr_pkg::FUNC_LOWER;
         else if (pick < 75) f = ptwsr_pkg::FUNC_QUERY;
         else if (pick < 97) f = ptwsr_pkg::FUNC_TICK;
         else                f = 3'($urandom_range(6, 7));
         pick = $urandom_range(0, 99);
         a = addr_pool[$urandom_range(0, POOL - 1)];
         if (pick >= 92) begin
            a = fresh_addr();
         end else if (pick >= 85) begin
            // Near miss: one bit away from a pooled key.
            bitpos = $urandom_range(0, ADDR_W - 1);
            a[bitpos] = ~a[bitpos];
         end
         offer_request(f, a);
         if (f <= ptwsr_pkg::FUNC_TICK) counted++;
      end
   endtask

   initial begin : stimulus
      logic [3:0]  phase_limit  [PHASES];
      logic [31:0] phase_stasis [PHASES];
      logic [ADDR_W-1:0] pa, pb, pc, pd;
      phase_limit  = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8, 4'd4, 4'd6};
      phase_stasis = '{32'd3, 32'd0, 32'd1, 32'd2, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd5,
                       32'd0, 32'd60};
      for (int k = 0; k < POOL; k++) addr_pool[k] = fresh_addr();
      pa = fresh_addr();
      pb = fresh_addr();
      pc = fresh_addr();
      pd = fresh_addr();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty table at reset settings: misses, tick and the unused codes.
      offer_request(ptwsr_pkg::FUNC_QUERY, '0);
      offer_request(ptwsr_pkg::FUNC_REMOVE, '1);
      offer_request(ptwsr_pkg::FUNC_RAISE, '1);
      offer_request(ptwsr_pkg::FUNC_LOWER, '0);
      offer_request(ptwsr_pkg::FUNC_TICK, pa);
      offer_request(3'd6, pa);
      offer_request(3'd7, '1);
      // Extreme keys, a duplicate insert and a raise request on a table that is not full.
      offer_request(ptwsr_pkg::FUNC_INSERT, '0);
      offer_request(ptwsr_pkg::FUNC_INSERT, '1);
      offer_request(ptwsr_pkg::FUNC_INSERT, '0);
      offer_request(ptwsr_pkg::FUNC_RAISE, '0);
      offer_request(ptwsr_pkg::FUNC_QUERY, '1);
      offer_request(ptwsr_pkg::FUNC_REMOVE, '1);

      // Two slots, one tick of stasis: fill, defer, score, then evict.
      wait_for_idle();
      apply_settings(4'd2, 32'd1);
      offer_request(ptwsr_pkg::FUNC_INSERT, pa);
      offer_request(ptwsr_pkg::FUNC_INSERT, pb);
      offer_request(ptwsr_pkg::FUNC_INSERT, pa);
      offer_request(ptwsr_pkg::FUNC_TICK, pc);
      offer_request(ptwsr_pkg::FUNC_RAISE, pa);
      offer_request(ptwsr_pkg::FUNC_RAISE, pa);
      offer_request(ptwsr_pkg::FUNC_LOWER, '0);
      offer_request(ptwsr_pkg::FUNC_INSERT, '0);
      offer_request(ptwsr_pkg::FUNC_INSERT, pb);
      offer_request(ptwsr_pkg::FUNC_TICK, pc);
      // All scores tied at zero after the refill, so the lowest slot goes.
      offer_request(ptwsr_pkg::FUNC_INSERT, pc);

      // Limit lowered below the current count: the table stays over the limit.
      wait_for_idle();
      apply_settings(4'd1, 32'd0);
      offer_request(ptwsr_pkg::FUNC_INSERT, pd);

      for (int p = 0; p < PHASES; p++)
         run_traffic_phase(phase_limit[p], phase_stasis[p], p == 2);

      wait_for_idle();
      repeat (20) @(posedge clock);
      $display("Sent %0d request items under %0d register settings, with one %0d-cycle stall.",
               items_sent, settings_used, HOLD_CYCLES);
      $display("Evictions predicted: %0d, deferred inserts: %0d, mismatches: %0d.",
               evictions, deferrals, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("peer_table_worst_score_replace regression: pass");
      end else begin
         $display("peer_table_worst_score_replace regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ptwsr_pkg.sv
hw/rtl/ptwsr_csr.sv
hw/rtl/ptwsr_search.sv
hw/rtl/peer_table_worst_score_replace.sv
bench/peer_table_worst_score_replace_check.sv
bench/peer_table_worst_score_replace_tb.sv
